/* hw/rtl/dtws_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the dual tone synthesizer.
// The table is built at elaboration by integer arithmetic and has no dependencies.
package dtws_pkg;

    localparam int TABLE_SIZE  = 1000;
    localparam int QTR_SPAN    = TABLE_SIZE / 4;
    localparam int QTR_DEPTH   = QTR_SPAN + 1;
    localparam int QTR_IDX_W   = $clog2(QTR_DEPTH);
    localparam int PHASE_INT_W = $clog2(TABLE_SIZE);
    localparam int PHASE_W     = 26;
    localparam int STEP_W      = 26;
    localparam int VOLUME_W    = 12;
    localparam int DAC_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int SINE_W      = 15;

    localparam logic [PHASE_W:0] PHASE_LIMIT   = (PHASE_W + 1)'(TABLE_SIZE * 65536);
    localparam logic [PHASE_W:0] PHASE_LIMIT_2 = (PHASE_W + 1)'(2 * TABLE_SIZE * 65536);

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_B = CFG_INDEX_W'(1);

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] M32         = 64'h00000000FFFFFFFF;

    // Denominator of the k-th Taylor step of the sine series, (2k)(2k+1).
    localparam logic [63:0] TAYLOR_DIV [1:29] = '{
        64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,  64'd272,
        64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,  64'd1056,
        64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162, 64'd2352,
        64'd2550, 64'd2756, 64'd2970, 64'd3192, 64'd3422
    };

    typedef logic [SINE_W-1:0] qtr_table_t [QTR_DEPTH];

    // Upper bits of a full 128-bit product, i.e. (a * b) >> 62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // floor(32767 * sin((pi/2) * num / TABLE_SIZE)) by a Taylor series in Q2.62.
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] num);
        logic [63:0] t1;
        logic [63:0] q1;
        logic [63:0] t2;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] mag;
        if (num == 64'd0) begin
            return '0;
        end
        if (num >= 64'(TABLE_SIZE)) begin
            return SINE_W'(32767);
        end
        t1   = (HALF_PI_Q62 >> 32) * num;
        q1   = t1 / 64'(TABLE_SIZE);
        t2   = ((t1 % 64'(TABLE_SIZE)) << 32) + (HALF_PI_Q62 & M32) * num;
        x    = (q1 << 32) + t2 / 64'(TABLE_SIZE);
        x2   = mul_q62(x, x);
        term = x;
        acc  = x;
        for (int k = 1; k < 30; k++) begin
            term = mul_q62(term, x2) / TAYLOR_DIV[k];
            if ((k % 2) == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        mag = mul_q62(acc, 64'd32767);
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return mag[SINE_W-1:0];
    endfunction

    // Entry k holds the sine magnitude at table index k of the first quadrant.
    function automatic qtr_table_t build_qtr_table();
        qtr_table_t tab;
        for (int k = 0; k < QTR_DEPTH; k++) begin
            tab[k] = quarter_sine(64'(4 * k));
        end
        return tab;
    endfunction

    localparam qtr_table_t QTR_SINE = build_qtr_table();

endpackage

/* hw/rtl/dual_tone_wavetable_synth.sv */
// Top level of the two-channel wavetable tone generator.
// Depends on dtws_pkg for widths, register codes and the sine table.

// Each accepted request on the s_ channel is one sample tick: both phase
// accumulators advance by their programmed steps (16 fraction bits, wrapping
// at 1000 table entries), the two sine words are looked up, summed, scaled
// by s_volume_level and offset to a 12-bit DAC code on m_dac_code with
// mid-scale at 2048. The block takes one request every clock cycle while
// the output is not stalled. A request's indexes, signs and volume are
// registered in the lookup stage and its result in the output register
// on m_dac_code; the phase accumulator update completes in the accept
// cycle, while lookup and scaling run in a second registered stage. The
// output register holds a result until it is taken, and a request may be
// accepted while a result waits, as long as the internal stage is free.
// Program step_a (index 0) and step_b (index 1) through the cfg_ port only
// while no request is in flight; writing a zero step also returns that
// channel's phase to zero, while a nonzero write keeps the phase.
module dual_tone_wavetable_synth
    import dtws_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]      cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VOLUME_W-1:0]    s_volume_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DAC_W-1:0]       m_dac_code
);

    // Programmed steps and phase accumulators.
    logic [STEP_W-1:0]  step_a_reg;
    logic [STEP_W-1:0]  step_b_reg;
    logic [PHASE_W-1:0] phase_a_reg;
    logic [PHASE_W-1:0] phase_b_reg;
    logic [PHASE_W-1:0] phase_a_next;
    logic [PHASE_W-1:0] phase_b_next;

    // Lookup stage: quarter-table index and sign of each tone plus the volume.
    logic                  s1_valid_reg;
    logic [QTR_IDX_W-1:0]  qidx_a_reg;
    logic [QTR_IDX_W-1:0]  qidx_b_reg;
    logic                  neg_a_reg;
    logic                  neg_b_reg;
    logic [VOLUME_W-1:0]   volume_reg;
    logic [QTR_IDX_W-1:0]  qidx_a_next;
    logic [QTR_IDX_W-1:0]  qidx_b_next;
    logic                  neg_a_next;
    logic                  neg_b_next;

    // Result register.
    logic              m_valid_reg;
    logic [DAC_W-1:0]  dac_reg;
    logic [DAC_W-1:0]  dac_next;

    logic in_fire;
    logic out_load;

    // One wrap suffices for steps below the limit, but a step may exceed it,
    // so the sum is reduced by either one or two table lengths.
    function automatic logic [PHASE_W-1:0] advance(input logic [PHASE_W-1:0] phase,
                                                   input logic [STEP_W-1:0]  step);
        logic [PHASE_W:0] total;
        total = {1'b0, phase} + {1'b0, step};
        if (total >= PHASE_LIMIT_2) begin
            total = total - PHASE_LIMIT_2;
        end else if (total >= PHASE_LIMIT) begin
            total = total - PHASE_LIMIT;
        end
        return total[PHASE_W-1:0];
    endfunction

    // Folds a full-table index into the first quadrant. The second quadrant
    // mirrors the first, and the second half of the cycle is negated.
    function automatic logic [QTR_IDX_W:0] fold_index(input logic [PHASE_INT_W-1:0] idx);
        logic [PHASE_INT_W:0] wide;
        logic [PHASE_INT_W:0] k;
        logic                 neg;
        wide = {1'b0, idx};
        if (wide < (PHASE_INT_W + 1)'(QTR_SPAN)) begin
            k   = wide;
            neg = 1'b0;
        end else if (wide < (PHASE_INT_W + 1)'(2 * QTR_SPAN)) begin
            k   = (PHASE_INT_W + 1)'(2 * QTR_SPAN) - wide;
            neg = 1'b0;
        end else if (wide < (PHASE_INT_W + 1)'(3 * QTR_SPAN)) begin
            k   = wide - (PHASE_INT_W + 1)'(2 * QTR_SPAN);
            neg = 1'b1;
        end else begin
            k   = (PHASE_INT_W + 1)'(4 * QTR_SPAN) - wide;
            neg = 1'b1;
        end
        return {neg, k[QTR_IDX_W-1:0]};
    endfunction

    // The lookup stage moves on whenever the result register is free or
    // being emptied, and takes a new request whenever it moves on or is empty.
    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || out_load;
    assign in_fire  = s_valid && s_ready;

    always_comb begin
        phase_a_next = advance(phase_a_reg, step_a_reg);
        phase_b_next = advance(phase_b_reg, step_b_reg);
        {neg_a_next, qidx_a_next} = fold_index(phase_a_next[PHASE_W-1 -: PHASE_INT_W]);
        {neg_b_next, qidx_b_next} = fold_index(phase_b_next[PHASE_W-1 -: PHASE_INT_W]);
    end

    // Lookup, sum, volume scaling and the floor shift toward the DAC code.
    always_comb begin
        logic signed [SINE_W+1:0]               sine_a;
        logic signed [SINE_W+1:0]               sine_b;
        logic signed [SINE_W+1:0]               sine_sum;
        logic signed [SINE_W+VOLUME_W+2:0]      prod;
        logic signed [SINE_W+VOLUME_W+2:0]      shifted;
        sine_a   = $signed({2'b00, QTR_SINE[qidx_a_reg]});
        sine_b   = $signed({2'b00, QTR_SINE[qidx_b_reg]});
        if (neg_a_reg) begin
            sine_a = -sine_a;
        end
        if (neg_b_reg) begin
            sine_b = -sine_b;
        end
        sine_sum = sine_a + sine_b;
        prod     = (SINE_W + VOLUME_W + 3)'(sine_sum) * $signed({5'd0, volume_reg});
        shifted  = prod >>> 17;
        dac_next = shifted[DAC_W-1:0] + DAC_W'(2048);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg   <= '0;
            step_b_reg   <= '0;
            phase_a_reg  <= '0;
            phase_b_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                phase_a_reg <= phase_a_next;
                phase_b_reg <= phase_b_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_A: begin
                        step_a_reg <= cfg_wdata;
                        if (cfg_wdata == '0) begin
                            phase_a_reg <= '0;
                        end
                    end
                    REG_STEP_B: begin
                        step_b_reg <= cfg_wdata;
                        if (cfg_wdata == '0) begin
                            phase_b_reg <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            qidx_a_reg <= qidx_a_next;
            qidx_b_reg <= qidx_b_next;
            neg_a_reg  <= neg_a_next;
            neg_b_reg  <= neg_b_next;
            volume_reg <= s_volume_level;
        end
        if (out_load) begin
            dac_reg <= dac_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_dac_code = dac_reg;

endmodule

/* sim/dac_code_checker.sv */
`timescale 1ns / 100ps
// Checker for the dual tone synthesizer: it watches the register port, the request
// channel and the result channel, predicts each DAC code and compares it with the output.
// Depends on dtws_pkg for widths, register codes and the table size.
module dac_code_checker
    import dtws_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]      cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [VOLUME_W-1:0]    s_volume_level,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [DAC_W-1:0]       m_dac_code,
    output int                     mismatch_count,
    output int                     codes_outstanding
);

    localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] WRAP_SPAN        = 64'(TABLE_SIZE) * 64'd65536;
    localparam int          SINE_PEAK        = 32767;
    localparam int          DAC_SHIFT        = 17;
    localparam int          DAC_MIDSCALE     = 2048;

    logic signed [15:0] sine_words [TABLE_SIZE];
    logic [STEP_W-1:0]  step_a;
    logic [STEP_W-1:0]  step_b;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    logic [DAC_W-1:0]   dac_code_due [$];
    logic [DAC_W-1:0]   oldest_code;

    // Bits 125:62 of the full product of two Q2.62 numbers.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return 64'(wide >> 62);
    endfunction

    // Truncated 32767*sin(pi/2 * num / TABLE_SIZE), odd Taylor terms in Q2.62.
    function automatic int sine_magnitude(input int num);
        logic [127:0] wide;
        logic [63:0]  angle;
        logic [63:0]  angle_sq;
        logic [63:0]  term;
        logic [63:0]  series;
        logic [63:0]  scaled;
        if (num == 0) begin
            return 0;
        end
        if (num >= TABLE_SIZE) begin
            return SINE_PEAK;
        end
        wide     = 128'(QUARTER_TURN_Q62) * 128'(num);
        angle    = 64'(wide / 128'(TABLE_SIZE));
        angle_sq = q62_mul(angle, angle);
        term     = angle;
        series   = angle;
        for (int k = 1; k < 30; k++) begin
            term   = q62_mul(term, angle_sq) / 64'((2 * k) * (2 * k + 1));
            series = (k % 2 == 1) ? series - term : series + term;
        end
        scaled = q62_mul(series, 64'(SINE_PEAK));
        return (scaled > 64'(SINE_PEAK)) ? SINE_PEAK : int'(scaled);
    endfunction

    function automatic logic [PHASE_W-1:0] advance_phase(input logic [PHASE_W-1:0] phase,
                                                         input logic [STEP_W-1:0] step);
        return PHASE_W'((64'(phase) + 64'(step)) % WRAP_SPAN);
    endfunction

    // One sample tick: both accumulators move, then the two tones are mixed.
    function automatic logic [DAC_W-1:0] next_dac_code(input logic [VOLUME_W-1:0] volume);
        int tone_sum;
        int scaled;
        phase_a  = advance_phase(phase_a, step_a);
        phase_b  = advance_phase(phase_b, step_b);
        tone_sum = int'(sine_words[phase_a >> 16]) + int'(sine_words[phase_b >> 16]);
        scaled   = (tone_sum * int'(volume)) >>> DAC_SHIFT;
        return DAC_W'(scaled + DAC_MIDSCALE);
    endfunction

    // Full wave from the first quadrant, mirrored in time and then in sign.
    initial begin
        int quad;
        int rem;
        int mag;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            quad = (4 * i) / TABLE_SIZE;
            rem  = 4 * i - quad * TABLE_SIZE;
            mag  = sine_magnitude((quad % 2 == 1) ? TABLE_SIZE - rem : rem);
            sine_words[i] = 16'((quad >= 2) ? -mag : mag);
        end
    end

    initial begin
        mismatch_count    = 0;
        codes_outstanding = 0;
        step_a  = '0;
        step_b  = '0;
        phase_a = '0;
        phase_b = '0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            step_a  = '0;
            step_b  = '0;
            phase_a = '0;
            phase_b = '0;
            dac_code_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (dac_code_due.size() == 0) begin
                    $display("%0t: unexpected dac_code, expected none, got %0d",
                             $time, m_dac_code);
                    mismatch_count++;
                end else begin
                    oldest_code = dac_code_due.pop_front();
                    if (m_dac_code !== oldest_code) begin
                        $display("%0t: dac_code mismatch, expected %0d, got %0d",
                                 $time, oldest_code, m_dac_code);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                dac_code_due.push_back(next_dac_code(s_volume_level));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_A: begin
                        step_a = cfg_wdata;
                        if (cfg_wdata == '0) begin
                            phase_a = '0;
                        end
                    end
                    REG_STEP_B: begin
                        step_b = cfg_wdata;
                        if (cfg_wdata == '0) begin
                            phase_b = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        codes_outstanding = dac_code_due.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the dual tone synthesizer testbench: clock, reset, step programming,
// volume requests and result back-pressure, with the verdict at the end.
// Depends on dtws_pkg, dual_tone_wavetable_synth and dac_code_checker.
module tb_top
    import dtws_pkg::*;
();

    // Timing of the run. The cycle limit is far above the slowest legal run:
    // up to 1021 requests, each behind a random sender gap and a receiver
    // that may take only one cycle in four, plus two long holds.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_SPACING = 400;
    localparam int TAIL_CYCLES  = 8;

    // Indexes 2 and 3 decode to no register; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

    // Step values of interest: one table entry per tick, a quarter turn per
    // tick (lands exactly on the sine peaks and zero crossings), the largest
    // legal step below one full turn, one full turn (phase stands still) and
    // the all-ones step, which is larger than a turn.
    localparam logic [STEP_W-1:0] STEP_ENTRY   = STEP_W'(65536);
    localparam logic [STEP_W-1:0] STEP_QUARTER = STEP_W'((TABLE_SIZE / 4) * 65536);
    localparam logic [STEP_W-1:0] STEP_WRAP    = STEP_W'(TABLE_SIZE * 65536);
    localparam logic [STEP_W-1:0] STEP_HIGH    = STEP_WRAP - STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_MAX     = '1;
    localparam logic [STEP_W-1:0] STEP_OFF     = '0;

    localparam logic [VOLUME_W-1:0] VOLUME_FULL = '1;
    localparam logic [VOLUME_W-1:0] VOLUME_MUTE = '0;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [STEP_W-1:0]      cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [VOLUME_W-1:0]    s_volume_level;
    logic                   m_valid;
    logic                   m_ready;
    logic [DAC_W-1:0]       m_dac_code;

    int mismatch_count;
    int codes_outstanding;
    int requests_sent;
    int random_sent;
    int burst_left;
    int cycle_count;

    dual_tone_wavetable_synth u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_volume_level (s_volume_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dac_code     (m_dac_code)
    );

    dac_code_checker u_dac_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_volume_level    (s_volume_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dac_code        (m_dac_code),
        .mismatch_count    (mismatch_count),
        .codes_outstanding (codes_outstanding)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog. A hang anywhere (a lost result, a stuck ready) ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // All drivers work on the falling edge, so the block and the checker see
    // stable inputs at every rising edge.

    // One register write. The enable drops again before the task returns so that
    // back-to-back writes never assign it twice in one time step.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [STEP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one volume request and hold it until the block takes it. Returns
    // on the falling edge after acceptance with valid still high, so the
    // caller either offers the next request or drops valid.
    task automatic send_volume(input logic [VOLUME_W-1:0] volume);
        s_valid        <= 1'b1;
        s_volume_level <= volume;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted code has been delivered.
    // Since every request yields exactly one code, nothing is left in flight
    // afterwards and the step registers may be rewritten.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (codes_outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    // Mostly ordinary tones, with a fair share of the step extremes.
    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return STEP_OFF;
            1: return STEP_MAX;
            2: return STEP_HIGH;
            3: return STEP_WRAP;
            4: return STEP_W'($urandom_range(1, 255));
            5, 6: return STEP_W'($urandom_range(1, 1 << 20));
            7: return STEP_W'($urandom_range(1, 65535) << 16);
            default: return STEP_W'($urandom_range(1, STEP_HIGH));
        endcase
    endfunction

    function automatic logic [VOLUME_W-1:0] pick_volume();
        case ($urandom_range(0, 9))
            0: return VOLUME_FULL;
            1: return VOLUME_MUTE;
            2: return VOLUME_W'($urandom_range(1, 15));
            default: return VOLUME_W'($urandom_range(0, VOLUME_FULL));
        endcase
    endfunction

    // A run of requests sent in bursts. Burst lengths reach well past the
    // pipeline depth so that long gap-free stretches occur, and the gaps fall
    // on every cycle of the two-stage pipeline.
    task automatic send_bursts(input int count);
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                burst_left = $urandom_range(1, 48);
            end
            send_volume(pick_volume());
            burst_left--;
        end
    endtask

    // One random phase: reprogram some registers while idle, then play a
    // stretch of samples. A nonzero rewrite keeps the phase, a zero one
    // clears it, and writes to the spare indexes must be ignored.
    task automatic random_phase();
        int count;
        count = $urandom_range(10, 100);
        case ($urandom_range(0, 3))
            0: begin
                write_register(REG_STEP_A, pick_step());
                write_register(REG_STEP_B, pick_step());
            end
            1: write_register(REG_STEP_A, pick_step());
            2: write_register(REG_STEP_B, pick_step());
            default: begin
                write_register(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                               STEP_W'($urandom()));
                write_register(REG_STEP_A, pick_step());
            end
        endcase
        send_bursts(count);
        random_sent += count;
        drain_results();
    endtask

    // Result side. The ready pattern changes between always ready, coin
    // flip, mostly stalled and mostly ready. Twice during the run, while a
    // request is on offer, ready is held low for a long stretch so that the
    // output register and the internal stage fill and the block has to drop
    // s_ready.
    initial begin
        int mode;
        int holds_done;
        int next_hold_at;
        m_ready      = 1'b0;
        holds_done   = 0;
        next_hold_at = 150;
        wait (aresetn === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 80)) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
            if (holds_done < 2 && requests_sent >= next_hold_at && s_valid) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
                next_hold_at += HOLD_SPACING;
            end
        end
    end

    // Request side and verdict.
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_STEP_A;
        cfg_wdata      = STEP_OFF;
        s_valid        = 1'b0;
        s_volume_level = VOLUME_MUTE;
        requests_sent  = 0;
        random_sent    = 0;
        burst_left     = 0;
        cycle_count    = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Out of reset both steps are zero: silence at mid-scale whatever
        // the volume.
        send_volume(VOLUME_FULL);
        send_volume(VOLUME_MUTE);
        drain_results();

        // Both tones a quarter turn per tick: the sum swings between the
        // positive peak, zero and the negative peak, driving the code to
        // both ends of its range at full volume.
        write_register(REG_STEP_A, STEP_QUARTER);
        write_register(REG_STEP_B, STEP_QUARTER);
        repeat (4) send_volume(VOLUME_FULL);
        drain_results();

        // Spare indexes decode to nothing; the tones must carry on unchanged.
        write_register(REG_SPARE_LO, STEP_MAX);
        write_register(REG_SPARE_HI, STEP_MAX);
        repeat (2) send_volume(VOLUME_FULL);
        drain_results();

        // A nonzero rewrite of tone A keeps its current phase.
        write_register(REG_STEP_A, STEP_ENTRY);
        send_volume(VOLUME_FULL);
        send_volume(VOLUME_W'(12'hAAA));
        send_volume(VOLUME_W'(12'h555));
        drain_results();

        // Zero step clears tone A's phase; tone B gets the all-ones step,
        // which is larger than one full turn.
        write_register(REG_STEP_A, STEP_OFF);
        write_register(REG_STEP_B, STEP_MAX);
        send_volume(VOLUME_FULL);
        send_volume(VOLUME_W'(12'h800));
        send_volume(VOLUME_W'(1));
        send_volume(VOLUME_MUTE);
        drain_results();

        // Largest step below a turn on A, exactly one turn on B.
        write_register(REG_STEP_A, STEP_HIGH);
        write_register(REG_STEP_B, STEP_WRAP);
        repeat (4) send_volume(VOLUME_FULL);
        drain_results();

        // Smallest step: the phase creeps along inside one table entry.
        write_register(REG_STEP_A, STEP_W'(1));
        write_register(REG_STEP_B, STEP_OFF);
        repeat (3) send_volume(VOLUME_FULL);
        drain_results();

        while (random_sent < RANDOM_ITEMS) begin
            random_phase();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
